### rtl/core/lmss_pkg.sv
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared constants and types for the LED matrix scan frame store.
// ----------------------------------------------------------------------------
package lmss_pkg;

   // panel geometry
   localparam int PANEL_COLUMNS_DEFAULT = 64;
   localparam int SCAN_ROWS             = 16;
   localparam int PLANE_COUNT           = 6;   // 3 colors x upper/lower half

   // field widths
   localparam int X_W     = 6;
   localparam int Y_W     = 5;
   localparam int VALUE_W = 8;
   localparam int ROW_W   = 4;
   localparam int BYTE_W  = 8;

   // RGB332 channel masks
   localparam logic [VALUE_W-1:0] RED_MASK   = 8'he0;
   localparam logic [VALUE_W-1:0] GREEN_MASK = 8'h1c;
   localparam logic [VALUE_W-1:0] BLUE_MASK  = 8'h03;

   // store byte value after reset
   localparam logic [BYTE_W-1:0] STORE_INIT = 8'hff;

   // request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_SCAN  = 1'b1;

   // memory access strobes from a client
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

### rtl/core/lmss_plane_ram.sv
// ----------------------------------------------------------------------------
// lmss_plane_ram
// Bit-plane store: one write port, one read port, registered read data that
// holds its value until the next read.
// ----------------------------------------------------------------------------
module lmss_plane_ram #(
   parameter int DEPTH = 768,
   parameter int AW    = 10
) (
   input  logic                        clock,
   input  lmss_pkg::mem_ctl_type       ctl,
   input  logic [AW-1:0]               rd_addr,
   input  logic [AW-1:0]               wr_addr,
   input  logic [lmss_pkg::BYTE_W-1:0] wr_data,
   output logic [lmss_pkg::BYTE_W-1:0] rd_data
);

   logic [lmss_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [lmss_pkg::BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held between reads
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lmss_pixel_unit.sv
// ----------------------------------------------------------------------------
// lmss_pixel_unit
// Pixel write sequencer: three read-modify-write accesses, one per color
// channel, overlapped so that each read's data is modified and written back
// in the following cycle.
// ----------------------------------------------------------------------------
module lmss_pixel_unit #(
   parameter int PANEL_COLUMNS = lmss_pkg::PANEL_COLUMNS_DEFAULT,
   parameter int AW            = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lmss_pkg::X_W-1:0]     pixel_x,
   input  logic [lmss_pkg::Y_W-1:0]     pixel_y,
   input  logic [lmss_pkg::VALUE_W-1:0] pixel_value,
   input  logic [lmss_pkg::BYTE_W-1:0]  rd_data,
   output lmss_pkg::mem_ctl_type        ctl,
   output logic [AW-1:0]                rd_addr,
   output logic [AW-1:0]                wr_addr,
   output logic [lmss_pkg::BYTE_W-1:0]  wr_data,
   output logic                         done
);

   localparam int ROW_BYTES = (lmss_pkg::PLANE_COUNT * PANEL_COLUMNS) / 8;
   localparam int PW        = $clog2(lmss_pkg::PLANE_COUNT * PANEL_COLUMNS);

   localparam logic [1:0] CHAN_RED   = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_BLUE  = 2'd2;
   localparam logic [1:0] PH_LAST    = 2'd3;

   logic                         busy_ff, busy_in;
   logic [1:0]                   ph_ff, ph_in;
   logic [lmss_pkg::X_W-1:0]     x_ff;
   logic [lmss_pkg::Y_W-1:0]     y_ff;
   logic [lmss_pkg::VALUE_W-1:0] value_ff;
   logic [AW-1:0]                wr_addr_ff;
   logic [lmss_pkg::BYTE_W-1:0]  mask_ff;
   logic                         on_ff;

   logic [2:0]                   factor;
   logic [PW-1:0]                bit_pos;
   logic [AW-1:0]                row_base;
   logic [AW-1:0]                byte_addr;
   logic [lmss_pkg::BYTE_W-1:0]  bit_mask;
   logic                         chan_on;

   // bit position: (5 - 2c - y/16) * columns + x
   always_comb begin
      factor    = 3'(lmss_pkg::PLANE_COUNT - 1) - {ph_ff, 1'b0} - {2'b00, y_ff[4]};
      bit_pos   = PW'(32'(factor) * 32'(PANEL_COLUMNS)) + PW'(x_ff);
      row_base  = AW'(32'(y_ff[3:0]) * 32'(ROW_BYTES));
      byte_addr = row_base + AW'(bit_pos[PW-1:3]);
      bit_mask  = 8'd1 << bit_pos[2:0];
   end

   // channel on/off from the RGB332 value
   always_comb begin
      case (ph_ff)
         CHAN_RED:   chan_on = |(value_ff & lmss_pkg::RED_MASK);
         CHAN_GREEN: chan_on = |(value_ff & lmss_pkg::GREEN_MASK);
         CHAN_BLUE:  chan_on = |(value_ff & lmss_pkg::BLUE_MASK);
         default:    chan_on = 1'b0;
      endcase
   end

   // sequencer
   always_comb begin
      busy_in = busy_ff;
      ph_in   = ph_ff;
      if (start) begin
         busy_in = 1'b1;
         ph_in   = CHAN_RED;
      end else if (busy_ff) begin
         ph_in = ph_ff + 2'd1;
         if (ph_ff == PH_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ph_ff   <= CHAN_RED;
      end else begin
         busy_ff <= busy_in;
         ph_ff   <= ph_in;
      end
   end

   // request latch and write-back pipeline
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff     <= pixel_x;
         y_ff     <= pixel_y;
         value_ff <= pixel_value;
      end
      if (busy_ff) begin
         wr_addr_ff <= byte_addr;
         mask_ff    <= bit_mask;
         on_ff      <= chan_on;
      end
   end

   // memory access: read channel ph, write back channel ph-1
   always_comb begin
      ctl.rd_en = busy_ff && (ph_ff != PH_LAST);
      ctl.wr_en = busy_ff && (ph_ff != CHAN_RED);
      rd_addr   = byte_addr;
      wr_addr   = wr_addr_ff;
      wr_data   = on_ff ? (rd_data | mask_ff) : (rd_data & ~mask_ff);
   end

   assign done = busy_ff && (ph_ff == PH_LAST);

endmodule

### rtl/core/lmss_scan_unit.sv
// ----------------------------------------------------------------------------
// lmss_scan_unit
// Row counter and row burst reader: advances the counter on a scan tick and
// streams the shift line of the following row through a read hold stage and
// an output register, one byte per cycle when the sink keeps up.
// ----------------------------------------------------------------------------
module lmss_scan_unit #(
   parameter int PANEL_COLUMNS = lmss_pkg::PANEL_COLUMNS_DEFAULT,
   parameter int AW            = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lmss_pkg::BYTE_W-1:0] rd_data,
   output lmss_pkg::mem_ctl_type       ctl,
   output logic [AW-1:0]               rd_addr,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lmss_pkg::ROW_W-1:0]  rsp_row_address,
   output logic [lmss_pkg::BYTE_W-1:0] rsp_shift_byte,
   output logic                        rsp_last_byte,
   output logic                        done
);

   localparam int ROW_BYTES = (lmss_pkg::PLANE_COUNT * PANEL_COLUMNS) / 8;
   localparam int CW        = $clog2(ROW_BYTES + 1);

   logic [lmss_pkg::ROW_W-1:0]  row_ff;
   logic                        active_ff;
   logic [CW-1:0]               cnt_ff;
   logic [AW-1:0]               addr_ff;
   logic                        rd_valid_ff;
   logic                        rd_last_ff;
   logic                        out_valid_ff;
   logic [lmss_pkg::BYTE_W-1:0] out_byte_ff;
   logic                        out_last_ff;

   logic [lmss_pkg::ROW_W-1:0]  scan_row;
   logic [AW-1:0]               scan_base;
   logic                        move;
   logic                        issue;

   // burst row is the one after the advanced counter
   always_comb begin
      scan_row  = row_ff + 4'd2;
      scan_base = AW'(32'(scan_row) * 32'(ROW_BYTES));
      move      = rd_valid_ff && (!out_valid_ff || rsp_ready);
      issue     = active_ff && (cnt_ff != CW'(ROW_BYTES)) && (!rd_valid_ff || move);
      done      = out_valid_ff && rsp_ready && out_last_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         active_ff    <= 1'b0;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            row_ff    <= row_ff + 4'd1;
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else begin
            if (done) begin
               active_ff <= 1'b0;
            end
            if (issue) begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
         if (issue) begin
            rd_valid_ff <= 1'b1;
         end else if (move) begin
            rd_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // address counter and data path
   always_ff @(posedge clock) begin
      if (start) begin
         addr_ff <= scan_base;
      end else if (issue) begin
         addr_ff <= addr_ff + AW'(1);
      end
      if (issue) begin
         rd_last_ff <= (cnt_ff == CW'(ROW_BYTES - 1));
      end
      if (move) begin
         out_byte_ff <= rd_data;
         out_last_ff <= rd_last_ff;
      end
   end

   always_comb begin
      ctl.rd_en = issue;
      ctl.wr_en = 1'b0;
      rd_addr   = addr_ff;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_row_address = row_ff;
   assign rsp_shift_byte  = out_byte_ff;
   assign rsp_last_byte   = out_last_ff;

endmodule

### rtl/core/led_matrix_scan_frame_store_top.sv
// Pixel write: accepted when req_ready is high, then a read-modify-write per color;
//   no new request is taken until it is done (req_ready is high only when idle).
// Scan tick: bytes go via a read hold stage and output register, 1 per cycle while
//   the sink is ready; 48 bytes per burst at 64 columns (6 * columns / 8).
// Reset: row counter cleared, then a clearing pass writes 0xff to every store
//   byte, one per cycle (768 bytes at 64 columns), with req_ready low.
// ----------------------------------------------------------------------------
// led_matrix_scan_frame_store_top
// Bit-plane frame store and row scanner for a 1/16 scan RGB LED panel.
// ----------------------------------------------------------------------------
module led_matrix_scan_frame_store_top #(
   parameter int PANEL_COLUMNS = lmss_pkg::PANEL_COLUMNS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic [lmss_pkg::X_W-1:0]     req_pixel_x,
   input  logic [lmss_pkg::Y_W-1:0]     req_pixel_y,
   input  logic [lmss_pkg::VALUE_W-1:0] req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lmss_pkg::ROW_W-1:0]   rsp_row_address,
   output logic [lmss_pkg::BYTE_W-1:0]  rsp_shift_byte,
   output logic                         rsp_last_byte
);

   localparam int ROW_BYTES   = (lmss_pkg::PLANE_COUNT * PANEL_COLUMNS) / 8;
   localparam int STORE_BYTES = lmss_pkg::SCAN_ROWS * ROW_BYTES;
   localparam int AW          = $clog2(STORE_BYTES);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_PIXEL = 4'b0100,
      ST_SCAN  = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;

   logic                        req_xfer;
   logic                        x_in_range;
   logic                        pixel_start;
   logic                        scan_start;

   lmss_pkg::mem_ctl_type       pix_ctl, scan_ctl, ram_ctl;
   logic [AW-1:0]               pix_rd_addr, pix_wr_addr, scan_rd_addr;
   logic [AW-1:0]               ram_rd_addr, ram_wr_addr;
   logic [lmss_pkg::BYTE_W-1:0] pix_wr_data, ram_wr_data, ram_rd_data;
   logic                        pixel_done, scan_done;

   // request decode
   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      req_xfer    = req_valid && req_ready;
      x_in_range  = 32'(req_pixel_x) < 32'(PANEL_COLUMNS);
      scan_start  = req_xfer && (req_mode == lmss_pkg::MODE_SCAN);
      pixel_start = req_xfer && (req_mode == lmss_pkg::MODE_WRITE) && x_in_range;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (scan_start) begin
               state_in = ST_SCAN;
            end else if (pixel_start) begin
               state_in = ST_PIXEL;
            end
         end
         ST_PIXEL: begin
            if (pixel_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // store port arbitration by state
   always_comb begin
      ram_ctl.rd_en = pix_ctl.rd_en | scan_ctl.rd_en;
      ram_ctl.wr_en = pix_ctl.wr_en | scan_ctl.wr_en | (state_ff == ST_CLEAR);
      ram_rd_addr   = (state_ff == ST_PIXEL) ? pix_rd_addr : scan_rd_addr;
      ram_wr_addr   = (state_ff == ST_CLEAR) ? clr_addr_ff : pix_wr_addr;
      ram_wr_data   = (state_ff == ST_CLEAR) ? lmss_pkg::STORE_INIT : pix_wr_data;
   end

   lmss_plane_ram #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_addr (ram_rd_addr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   lmss_pixel_unit #(
      .PANEL_COLUMNS (PANEL_COLUMNS),
      .AW            (AW)
   ) u_pixel (
      .clock       (clock),
      .reset       (reset),
      .start       (pixel_start),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .pixel_value (req_pixel_value),
      .rd_data     (ram_rd_data),
      .ctl         (pix_ctl),
      .rd_addr     (pix_rd_addr),
      .wr_addr     (pix_wr_addr),
      .wr_data     (pix_wr_data),
      .done        (pixel_done)
   );

   lmss_scan_unit #(
      .PANEL_COLUMNS (PANEL_COLUMNS),
      .AW            (AW)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .start           (scan_start),
      .rd_data         (ram_rd_data),
      .ctl             (scan_ctl),
      .rd_addr         (scan_rd_addr),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_address (rsp_row_address),
      .rsp_shift_byte  (rsp_shift_byte),
      .rsp_last_byte   (rsp_last_byte),
      .done            (scan_done)
   );

endmodule

### bench/lmss_scan_checker.sv
// ----------------------------------------------------------------------------
// lmss_scan_checker
// Watches the request and response channels of the LED matrix scan frame
// store. It keeps its own bit-plane image and row counter, and compares each
// streamed byte with the one predicted for it.
// ----------------------------------------------------------------------------
module lmss_scan_checker #(
   parameter int PANEL_COLUMNS = lmss_pkg::PANEL_COLUMNS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_mode,
   input  logic [lmss_pkg::X_W-1:0]     req_pixel_x,
   input  logic [lmss_pkg::Y_W-1:0]     req_pixel_y,
   input  logic [lmss_pkg::VALUE_W-1:0] req_pixel_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [lmss_pkg::ROW_W-1:0]   rsp_row_address,
   input  logic [lmss_pkg::BYTE_W-1:0]  rsp_shift_byte,
   input  logic                         rsp_last_byte,
   output int                           fail_count,
   output int                           pending_count
);
   import lmss_pkg::*;

   localparam int ROW_BYTES   = (PLANE_COUNT * PANEL_COLUMNS) / 8;
   localparam int STORE_BYTES = SCAN_ROWS * ROW_BYTES;

   typedef struct {
      logic [ROW_W-1:0]  row_address;
      logic [BYTE_W-1:0] shift_byte;
      logic              last_byte;
   } row_beat_type;

   logic [BYTE_W-1:0] plane_image [STORE_BYTES];
   logic [ROW_W-1:0]  scan_row;
   row_beat_type      row_beats [$];
   int                errors;

   // set or clear one color bit of a pixel in the plane image
   task automatic put_color_bit(int x, int y, int chan, bit on);
      int base;
      int sub;
      int pos;
      int idx;
      base = PLANE_COUNT * PANEL_COLUMNS - 1;
      sub  = (y >> 4) * PANEL_COLUMNS + (PANEL_COLUMNS - 1 - x)
           + 2 * PANEL_COLUMNS * chan;
      if (sub > base) return;
      pos = base - sub;
      idx = (y % SCAN_ROWS) * ROW_BYTES + pos / 8;
      if (idx >= STORE_BYTES) return;
      plane_image[idx][pos % 8] = on;
   endtask

   // reduce an RGB332 value to three on/off bits and place them
   task automatic write_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                              logic [VALUE_W-1:0] v);
      if (int'(x) >= PANEL_COLUMNS) return;   // column off the panel
      put_color_bit(int'(x), int'(y), 0, |(v & RED_MASK));
      put_color_bit(int'(x), int'(y), 1, |(v & GREEN_MASK));
      put_color_bit(int'(x), int'(y), 2, |(v & BLUE_MASK));
   endtask

   // advance the row counter and queue the shift line of the following row
   task automatic queue_row_burst();
      row_beat_type     b;
      logic [ROW_W-1:0] shown_row;
      int               start;
      scan_row  = scan_row + ROW_W'(1);
      shown_row = scan_row + ROW_W'(1);
      start     = int'(shown_row) * ROW_BYTES;
      for (int k = 0; k < ROW_BYTES; k++) begin
         b.row_address = scan_row;
         b.shift_byte  = plane_image[start + k];
         b.last_byte   = (k == ROW_BYTES - 1);
         row_beats.push_back(b);
      end
   endtask

   // compare one response transfer with the oldest queued beat
   task automatic check_beat();
      row_beat_type want;
      if (row_beats.size() == 0) begin
         errors++;
         $display("%0t: expected no beat, got row %0d byte %02h last %0b", $time,
                  rsp_row_address, rsp_shift_byte, rsp_last_byte);
         return;
      end
      want = row_beats.pop_front();
      if (rsp_row_address !== want.row_address || rsp_shift_byte !== want.shift_byte
          || rsp_last_byte !== want.last_byte) begin
         errors++;
         $display("%0t: expected row %0d byte %02h last %0b, got row %0d byte %02h last %0b",
                  $time, want.row_address, want.shift_byte, want.last_byte,
                  rsp_row_address, rsp_shift_byte, rsp_last_byte);
      end
   endtask

   // sample both channels at the rising edge; response first, then request
   always @(posedge clock) begin
      if (reset) begin
         foreach (plane_image[i]) plane_image[i] = STORE_INIT;
         scan_row = '0;
         row_beats.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_beat();
         if (req_valid && req_ready) begin
            if (req_mode == MODE_SCAN) queue_row_burst();
            else write_pixel(req_pixel_x, req_pixel_y, req_pixel_value);
         end
      end
      fail_count    <= errors;
      pending_count <= row_beats.size();
   end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the LED matrix scan frame store: directed pixel writes and
// scan ticks, then bursty random traffic against a stalling receiver, with
// a checker beside the block predicting every streamed byte.
// ----------------------------------------------------------------------------
module tb_top;
   import lmss_pkg::*;

   localparam int COLUMNS      = PANEL_COLUMNS_DEFAULT;
   localparam int RANDOM_ITEMS = 360;
   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_mode;
   logic [X_W-1:0]     req_pixel_x;
   logic [Y_W-1:0]     req_pixel_y;
   logic [VALUE_W-1:0] req_pixel_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [ROW_W-1:0]   rsp_row_address;
   logic [BYTE_W-1:0]  rsp_shift_byte;
   logic               rsp_last_byte;

   int fail_count;
   int pending_count;
   int idle_cycles;
   bit hold_wanted;

   led_matrix_scan_frame_store_top #(
      .PANEL_COLUMNS(COLUMNS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_row_address(rsp_row_address),
      .rsp_shift_byte(rsp_shift_byte),
      .rsp_last_byte(rsp_last_byte)
   );

   lmss_scan_checker #(
      .PANEL_COLUMNS(COLUMNS)
   ) scan_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_row_address(rsp_row_address),
      .rsp_shift_byte(rsp_shift_byte),
      .rsp_last_byte(rsp_last_byte),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog: cycles in a row with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver: stretches of varying stall patterns, plus one long hold-off
   initial begin
      int kind;
      int len;
      int held;
      bit hold_done;
      held      = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         kind = $urandom_range(0, 3);
         len  = $urandom_range(4, 40);
         for (int i = 0; i < len; i++) begin
            @(negedge clock);
            if (hold_wanted && !hold_done) begin
               rsp_ready <= 1'b0;
               held++;
               if (held >= HOLD_CYCLES) hold_done = 1'b1;
            end else begin
               case (kind)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= (i % 4 != 3);
                  default: rsp_ready <= ($urandom_range(0, 7) == 0);
               endcase
            end
         end
      end
   end

   // offer one request and wait for its transfer
   task automatic send_item(logic mode, logic [X_W-1:0] x, logic [Y_W-1:0] y,
                            logic [VALUE_W-1:0] v);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_pixel_x     <= x;
      req_pixel_y     <= y;
      req_pixel_value <= v;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // sender gap with req_valid held low
   task automatic pause_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // RGB332 value: either fully random or with a random set of channels lit
   function automatic logic [VALUE_W-1:0] pick_color();
      logic [VALUE_W-1:0] m;
      if ($urandom_range(0, 1) == 0) return VALUE_W'($urandom_range(0, 255));
      m = '0;
      if ($urandom_range(0, 1)) m = m | RED_MASK;
      if ($urandom_range(0, 1)) m = m | GREEN_MASK;
      if ($urandom_range(0, 1)) m = m | BLUE_MASK;
      return VALUE_W'($urandom_range(0, 255)) & m;
   endfunction

   // stimulus and verdict
   initial begin
      int  burst_left;
      logic mode;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_WRITE;
      req_pixel_x     = '0;
      req_pixel_y     = '0;
      req_pixel_value = '0;
      hold_wanted     = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: corner pixels, both halves, each channel alone
      send_item(MODE_WRITE, 6'd0,  5'd0,  8'h00);
      send_item(MODE_WRITE, 6'd63, 5'd0,  8'hff);
      send_item(MODE_WRITE, 6'd63, 5'd31, 8'he0);
      send_item(MODE_WRITE, 6'd0,  5'd31, 8'h1c);
      send_item(MODE_WRITE, 6'd0,  5'd16, 8'h03);
      send_item(MODE_WRITE, 6'd63, 5'd15, 8'hff);
      // pixels on the row shown by the first tick (row 2, upper and lower)
      send_item(MODE_WRITE, 6'd0,  5'd2,  8'h00);
      send_item(MODE_WRITE, 6'd63, 5'd18, 8'h00);
      send_item(MODE_WRITE, 6'd10, 5'd2,  8'h20);
      send_item(MODE_WRITE, 6'd20, 5'd18, 8'h04);
      send_item(MODE_WRITE, 6'd30, 5'd2,  8'h01);
      send_item(MODE_WRITE, 6'd63, 5'd2,  8'h40);
      send_item(MODE_SCAN,  6'd0,  5'd0,  8'h00);
      // row 3, then a tick with all pixel fields high (they are ignored)
      send_item(MODE_WRITE, 6'd0,  5'd3,  8'h00);
      send_item(MODE_WRITE, 6'd63, 5'd19, 8'h02);
      send_item(MODE_WRITE, 6'd32, 5'd3,  8'h08);
      send_item(MODE_SCAN,  6'd63, 5'd31, 8'hff);
      // a never-written row still reads back all ones
      send_item(MODE_SCAN,  6'd21, 5'd10, 8'h55);

      // random: start with ticks while the receiver holds off to fill the block
      hold_wanted = 1'b1;
      burst_left  = $urandom_range(1, 16);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            pause_req($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 16);
         end
         mode = (i < 8 || $urandom_range(0, 6) == 0) ? MODE_SCAN : MODE_WRITE;
         send_item(mode, X_W'($urandom_range(0, 63)), Y_W'($urandom_range(0, 31)),
                   pick_color());
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then a further wait for stray beats
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
